// ===== rtl/arlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package arlp_pkg;

   localparam int LINE_SIZE    = 256;
   localparam int MAX_PAYLOAD  = 64;
   localparam int ROUTE_WINDOW = 63;
   localparam int LINE_AW      = $clog2(LINE_SIZE);
   localparam int POS_W        = LINE_AW + 1;
   localparam int NUM_BANKS    = 4;
   localparam int BANK_AW      = $clog2(NUM_BANKS);
   localparam int RAM_DEPTH    = NUM_BANKS * LINE_SIZE;
   localparam int RAM_AW       = BANK_AW + LINE_AW;

   localparam logic [1:0] KIND_OK    = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;
   localparam logic [1:0] KIND_ROUTE = 2'd3;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_RBRK  = 8'h5D;

   typedef enum logic [1:0] {
      CLS_OK    = 2'd0,
      CLS_ERR   = 2'd1,
      CLS_NNMI  = 2'd2,
      CLS_ROUTE = 2'd3
   } cls_type;

   // One finished line handed from the front end to the back end.
   typedef struct packed {
      cls_type              cls;
      logic [BANK_AW-1:0]   bank;
      logic [LINE_AW-1:0]   text_len;
   } token_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_nib(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= "0" && c <= "9") begin
         v = c - 8'h30;
      end else if (c >= "a" && c <= "f") begin
         v = c - 8'h57;
      end else if (c >= "A" && c <= "F") begin
         v = c - 8'h37;
      end
      hex_nib = v[3:0];
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      is_dec = (c >= "0") && (c <= "9");
   endfunction

endpackage
`default_nettype wire

// ===== rtl/arlp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module arlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/arlp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module arlp_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        byte_valid,
   output logic                             byte_ready,
   input  wire logic [7:0]                  byte_data,
   output logic                             wr_en,
   output logic [arlp_pkg::RAM_AW-1:0]      wr_addr,
   output logic [7:0]                       wr_data,
   input  wire logic                        q_full,
   output logic                             push,
   output arlp_pkg::token_type              push_token
);
   import arlp_pkg::*;

   localparam logic [15:0] LIT_OK    = "OK";
   localparam logic [39:0] LIT_ERR   = "ERROR";
   localparam logic [47:0] LIT_NNMI  = "+NNMI:";
   localparam logic [55:0] LIT_ROUTE = "+ROUTE:";

   logic [LINE_AW-1:0] len_ff, len_in;
   logic [39:0]        hist_ff, hist_in;
   logic               prev_cr_ff, prev_cr_in;
   logic               zero_seen_ff, zero_seen_in;
   logic [LINE_AW-1:0] zero_pos_ff, zero_pos_in;
   logic               pre_ok_ff, pre_ok_in;
   logic               pre_err_ff, pre_err_in;
   logic               pre_nnmi_ff, pre_nnmi_in;
   logic               pre_route_ff, pre_route_in;
   logic               plus_ff, plus_in;
   logic               colok_ff, colok_in;
   logic [LINE_AW-1:0] colok_end_ff, colok_end_in;
   logic               colerr_ff, colerr_in;
   logic [BANK_AW-1:0] bank_ff, bank_in;

   logic               accept;
   logic [LINE_AW-1:0] text_len;
   logic               is_ok, is_err, is_nnmi, is_route;

   assign byte_ready = !q_full;
   assign accept     = byte_valid && byte_ready;
   assign wr_addr    = {bank_ff, len_ff};
   assign wr_data    = byte_data;

   always_comb begin
      len_in       = len_ff;
      hist_in      = hist_ff;
      prev_cr_in   = prev_cr_ff;
      zero_seen_in = zero_seen_ff;
      zero_pos_in  = zero_pos_ff;
      pre_ok_in    = pre_ok_ff;
      pre_err_in   = pre_err_ff;
      pre_nnmi_in  = pre_nnmi_ff;
      pre_route_in = pre_route_ff;
      plus_in      = plus_ff;
      colok_in     = colok_ff;
      colok_end_in = colok_end_ff;
      colerr_in    = colerr_ff;
      bank_in      = bank_ff;
      wr_en        = 1'b0;
      push         = 1'b0;
      text_len     = zero_seen_ff ? zero_pos_ff : (len_ff - LINE_AW'(1));
      is_ok    = (pre_ok_ff && text_len == LINE_AW'(2)) ||
                 (plus_ff && colok_ff && colok_end_ff == text_len);
      is_err   = (pre_err_ff && text_len >= LINE_AW'(5)) || (plus_ff && colerr_ff);
      is_nnmi  = pre_nnmi_ff && text_len >= LINE_AW'(6);
      is_route = pre_route_ff && text_len >= LINE_AW'(7);
      push_token.bank     = bank_ff;
      push_token.text_len = text_len;
      priority if (is_ok) begin
         push_token.cls = CLS_OK;
      end else if (is_err) begin
         push_token.cls = CLS_ERR;
      end else if (is_nnmi) begin
         push_token.cls = CLS_NNMI;
      end else begin
         push_token.cls = CLS_ROUTE;
      end

      if (accept) begin
         if (len_ff != LINE_AW'(LINE_SIZE - 1)) begin
            wr_en      = 1'b1;
            len_in     = len_ff + LINE_AW'(1);
            hist_in    = {hist_ff[31:0], byte_data};
            prev_cr_in = (byte_data == CH_CR);
            if (byte_data == 8'd0 && !zero_seen_ff) begin
               zero_seen_in = 1'b1;
               zero_pos_in  = len_ff;
            end
            if (len_ff < LINE_AW'(2)) begin
               pre_ok_in = pre_ok_ff && (byte_data == LIT_OK[(3'd1 - 3'(len_ff)) * 8 +: 8]);
            end
            if (len_ff < LINE_AW'(5)) begin
               pre_err_in = pre_err_ff && (byte_data == LIT_ERR[(3'd4 - 3'(len_ff)) * 8 +: 8]);
            end
            if (len_ff < LINE_AW'(6)) begin
               pre_nnmi_in = pre_nnmi_ff &&
                             (byte_data == LIT_NNMI[(3'd5 - 3'(len_ff)) * 8 +: 8]);
            end
            if (len_ff < LINE_AW'(7)) begin
               pre_route_in = pre_route_ff &&
                              (byte_data == LIT_ROUTE[(3'd6 - 3'(len_ff)) * 8 +: 8]);
            end
            if (len_ff == LINE_AW'(0)) begin
               plus_in = (byte_data == CH_PLUS);
            end
            // Substring hits only count inside the text, which ends at the first zero.
            if (!zero_seen_ff && !colok_ff && hist_ff[15:0] == ":O" && byte_data == "K") begin
               colok_in     = 1'b1;
               colok_end_in = len_ff + LINE_AW'(1);
            end
            if (!zero_seen_ff && hist_ff == ":ERRO" && byte_data == "R") begin
               colerr_in = 1'b1;
            end
         end
         if (len_ff == LINE_AW'(LINE_SIZE - 1) || (prev_cr_ff && byte_data == CH_LF)) begin
            if (len_ff != LINE_AW'(LINE_SIZE - 1) && text_len != LINE_AW'(0) &&
                (is_ok || is_err || is_nnmi || is_route)) begin
               push    = 1'b1;
               bank_in = bank_ff + BANK_AW'(1);
            end
            len_in       = '0;
            hist_in      = '0;
            prev_cr_in   = 1'b0;
            zero_seen_in = 1'b0;
            pre_ok_in    = 1'b1;
            pre_err_in   = 1'b1;
            pre_nnmi_in  = 1'b1;
            pre_route_in = 1'b1;
            plus_in      = 1'b0;
            colok_in     = 1'b0;
            colerr_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         hist_ff      <= '0;
         prev_cr_ff   <= 1'b0;
         zero_seen_ff <= 1'b0;
         pre_ok_ff    <= 1'b1;
         pre_err_ff   <= 1'b1;
         pre_nnmi_ff  <= 1'b1;
         pre_route_ff <= 1'b1;
         plus_ff      <= 1'b0;
         colok_ff     <= 1'b0;
         colerr_ff    <= 1'b0;
         bank_ff      <= '0;
      end else begin
         len_ff       <= len_in;
         hist_ff      <= hist_in;
         prev_cr_ff   <= prev_cr_in;
         zero_seen_ff <= zero_seen_in;
         pre_ok_ff    <= pre_ok_in;
         pre_err_ff   <= pre_err_in;
         pre_nnmi_ff  <= pre_nnmi_in;
         pre_route_ff <= pre_route_in;
         plus_ff      <= plus_in;
         colok_ff     <= colok_in;
         colerr_ff    <= colerr_in;
         bank_ff      <= bank_in;
      end
      zero_pos_ff  <= zero_pos_in;
      colok_end_ff <= colok_end_in;
   end

endmodule
`default_nettype wire

// ===== rtl/arlp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module arlp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  arlp_pkg::token_type      push_token,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output arlp_pkg::token_type      pop_token
);
   import arlp_pkg::*;

   token_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_token = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/arlp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module arlp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_not_empty,
   input  arlp_pkg::token_type           q_token,
   output logic                          pop,
   output logic [arlp_pkg::RAM_AW-1:0]   rd_addr,
   input  wire logic [7:0]               rd_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [1:0]                    out_kind,
   output logic [15:0]                   out_source_id,
   output logic [7:0]                    out_data_byte,
   output logic [6:0]                    out_payload_length,
   output logic [15:0]                   out_route_address,
   output logic                          out_last
);
   import arlp_pkg::*;

   localparam int CMP_W = POS_W + 9;

   typedef enum logic [16:0] {
      B_IDLE    = 17'b00000000000000001,
      B_EMIT    = 17'b00000000000000010,
      D_SP_SRC  = 17'b00000000000000100,
      D_SRC     = 17'b00000000000001000,
      D_SP_DEST = 17'b00000000000010000,
      D_DEST    = 17'b00000000000100000,
      D_SP_RSSI = 17'b00000000001000000,
      D_SIGN    = 17'b00000000010000000,
      D_RSSI    = 17'b00000000100000000,
      D_SP_LEN  = 17'b00000001000000000,
      D_LEN     = 17'b00000010000000000,
      D_SP_PAY  = 17'b00000100000000000,
      D_HI      = 17'b00001000000000000,
      D_LO      = 17'b00010000000000000,
      R_SP      = 17'b00100000000000000,
      R_FIND    = 17'b01000000000000000,
      R_HEX     = 17'b10000000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [BANK_AW-1:0] bank_ff, bank_in;
   logic [LINE_AW-1:0] tl_ff, tl_in;
   logic [POS_W-1:0]   restart_ff, restart_in;
   logic [POS_W-1:0]   lim_ff, lim_in;
   logic               got_ff, got_in;
   logic [7:0]         num_ff, num_in;
   logic [15:0]        val_ff, val_in;
   logic [31:0]        hist_ff, hist_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [6:0]         idx_ff, idx_in;
   logic               hv_ff, hv_in;
   logic [3:0]         hn_ff, hn_in;
   logic [1:0]         ekind_ff, ekind_in;

   logic               ov_ff, ov_in;
   logic [1:0]         ok_ff, ok_in;
   logic [15:0]        osrc_ff, osrc_in;
   logic [7:0]         odat_ff, odat_in;
   logic [6:0]         olen_ff, olen_in;
   logic [15:0]        oadr_ff, oadr_in;
   logic               olast_ff, olast_in;

   logic [7:0]         ch;
   logic               out_free;
   logic [11:0]        dec_next;
   logic [POS_W+7:0]   lim_wide;
   logic [CMP_W-1:0]   room;
   logic [7:0]         idx_next;

   assign ch       = (pos_ff < POS_W'(tl_ff)) ? rd_data : 8'd0;
   assign out_free = !ov_ff || out_ready;
   assign rd_addr  = {bank_in, pos_in[LINE_AW-1:0]};
   assign dec_next = {num_ff, 3'b000} + {3'b000, num_ff, 1'b0} + {8'd0, ch[3:0]};
   assign lim_wide = {8'd0, pos_ff} + (POS_W + 8)'(ROUTE_WINDOW);
   assign room     = CMP_W'(POS_W'(tl_ff) - pos_ff);
   assign idx_next = {1'b0, idx_ff} + 8'd1;

   assign out_valid          = ov_ff;
   assign out_kind           = ok_ff;
   assign out_source_id      = osrc_ff;
   assign out_data_byte      = odat_ff;
   assign out_payload_length = olen_ff;
   assign out_route_address  = oadr_ff;
   assign out_last           = olast_ff;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      bank_in    = bank_ff;
      tl_in      = tl_ff;
      restart_in = restart_ff;
      lim_in     = lim_ff;
      got_in     = got_ff;
      num_in     = num_ff;
      val_in     = val_ff;
      hist_in    = hist_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      hv_in      = hv_ff;
      hn_in      = hn_ff;
      ekind_in   = ekind_ff;
      ov_in      = ov_ff && !out_ready;
      ok_in      = ok_ff;
      osrc_in    = osrc_ff;
      odat_in    = odat_ff;
      olen_in    = olen_ff;
      oadr_in    = oadr_ff;
      olast_in   = olast_ff;
      pop        = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (q_not_empty) begin
               pop     = 1'b1;
               bank_in = q_token.bank;
               tl_in   = q_token.text_len;
               got_in  = 1'b0;
               val_in  = '0;
               unique case (q_token.cls)
                  CLS_OK: begin
                     ekind_in = KIND_OK;
                     state_in = B_EMIT;
                  end
                  CLS_ERR: begin
                     ekind_in = KIND_ERROR;
                     state_in = B_EMIT;
                  end
                  CLS_NNMI: begin
                     pos_in   = POS_W'(6);
                     state_in = D_SP_SRC;
                  end
                  CLS_ROUTE: begin
                     ekind_in = KIND_ROUTE;
                     pos_in   = POS_W'(7);
                     state_in = R_SP;
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_EMIT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               ok_in    = ekind_ff;
               osrc_in  = '0;
               odat_in  = '0;
               olen_in  = '0;
               oadr_in  = val_ff;
               olast_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         D_SP_SRC: begin
            if (ch == CH_SPACE) begin
               pos_in = pos_ff + POS_W'(1);
            end else begin
               state_in = D_SRC;
            end
         end
         D_SRC: begin
            if (is_hex(ch)) begin
               val_in = {val_ff[11:0], hex_nib(ch)};
               got_in = 1'b1;
               pos_in = pos_ff + POS_W'(1);
            end else if (got_ff && ch == CH_COMMA) begin
               got_in   = 1'b0;
               pos_in   = pos_ff + POS_W'(1);
               state_in = D_SP_DEST;
            end else begin
               state_in = B_IDLE;
            end
         end
         D_SP_DEST: begin
            if (ch == CH_SPACE) begin
               pos_in = pos_ff + POS_W'(1);
            end else begin
               restart_in = pos_ff;
               state_in   = D_DEST;
            end
         end
         D_DEST: begin
            if (is_hex(ch)) begin
               got_in = 1'b1;
               pos_in = pos_ff + POS_W'(1);
            end else if (got_ff && ch == CH_COMMA) begin
               got_in   = 1'b0;
               pos_in   = pos_ff + POS_W'(1);
               state_in = D_SP_RSSI;
            end else begin
               // Not the new form: read the length right after the source.
               got_in   = 1'b0;
               num_in   = '0;
               pos_in   = restart_ff;
               state_in = D_LEN;
            end
         end
         D_SP_RSSI: begin
            if (ch == CH_SPACE) begin
               pos_in = pos_ff + POS_W'(1);
            end else begin
               state_in = D_SIGN;
            end
         end
         D_SIGN: begin
            if (ch == CH_PLUS || ch == CH_MINUS) begin
               pos_in = pos_ff + POS_W'(1);
            end
            got_in   = 1'b0;
            state_in = D_RSSI;
         end
         D_RSSI: begin
            if (is_dec(ch)) begin
               got_in = 1'b1;
               pos_in = pos_ff + POS_W'(1);
            end else if (got_ff && ch == CH_COMMA) begin
               got_in   = 1'b0;
               pos_in   = pos_ff + POS_W'(1);
               state_in = D_SP_LEN;
            end else begin
               got_in   = 1'b0;
               num_in   = '0;
               pos_in   = restart_ff;
               state_in = D_LEN;
            end
         end
         D_SP_LEN: begin
            if (ch == CH_SPACE) begin
               pos_in = pos_ff + POS_W'(1);
            end else begin
               got_in   = 1'b0;
               num_in   = '0;
               state_in = D_LEN;
            end
         end
         D_LEN: begin
            if (is_dec(ch)) begin
               num_in = (dec_next > 12'd255) ? 8'd255 : dec_next[7:0];
               got_in = 1'b1;
               pos_in = pos_ff + POS_W'(1);
            end else if (got_ff && ch == CH_COMMA) begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = D_SP_PAY;
            end else begin
               state_in = B_IDLE;
            end
         end
         D_SP_PAY: begin
            if (ch == CH_SPACE) begin
               pos_in = pos_ff + POS_W'(1);
            end else if (num_ff > 8'(MAX_PAYLOAD) || pos_ff > POS_W'(tl_ff) ||
                         room < CMP_W'({num_ff, 1'b0}) || num_ff == 8'd0) begin
               state_in = B_IDLE;
            end else begin
               idx_in   = '0;
               state_in = D_HI;
            end
         end
         D_HI: begin
            hv_in    = is_hex(ch);
            hn_in    = hex_nib(ch);
            pos_in   = pos_ff + POS_W'(1);
            state_in = D_LO;
         end
         D_LO: begin
            if (out_free) begin
               ov_in   = 1'b1;
               ok_in   = KIND_DATA;
               osrc_in = val_ff;
               if (!hv_ff) begin
                  odat_in = 8'd0;
               end else if (is_hex(ch)) begin
                  odat_in = {hn_ff, hex_nib(ch)};
               end else begin
                  odat_in = {4'd0, hn_ff};
               end
               olen_in  = num_ff[6:0];
               oadr_in  = '0;
               olast_in = (idx_next == num_ff);
               idx_in   = idx_next[6:0];
               pos_in   = pos_ff + POS_W'(1);
               state_in = (idx_next == num_ff) ? B_IDLE : D_HI;
            end
         end
         R_SP: begin
            if (ch == CH_SPACE) begin
               pos_in = pos_ff + POS_W'(1);
            end else begin
               lim_in   = (lim_wide > (POS_W + 8)'(tl_ff)) ? POS_W'(tl_ff) : lim_wide[POS_W-1:0];
               hist_in  = '0;
               state_in = R_FIND;
            end
         end
         R_FIND: begin
            if (pos_ff >= lim_ff) begin
               state_in = B_EMIT;
            end else if (hist_ff == "ADDR" && ch == "[") begin
               cnt_in   = '0;
               pos_in   = pos_ff + POS_W'(1);
               state_in = R_HEX;
            end else begin
               hist_in = {hist_ff[23:0], ch};
               pos_in  = pos_ff + POS_W'(1);
            end
         end
         R_HEX: begin
            if (pos_ff < lim_ff && ch != CH_RBRK && cnt_ff < 4'd8) begin
               if (is_hex(ch)) begin
                  val_in = {val_ff[11:0], hex_nib(ch)};
                  cnt_in = cnt_ff + 4'd1;
               end
               pos_in = pos_ff + POS_W'(1);
            end else begin
               state_in = B_EMIT;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         ov_ff    <= 1'b0;
         pos_ff   <= '0;
         bank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         pos_ff   <= pos_in;
         bank_ff  <= bank_in;
      end
      tl_ff      <= tl_in;
      restart_ff <= restart_in;
      lim_ff     <= lim_in;
      got_ff     <= got_in;
      num_ff     <= num_in;
      val_ff     <= val_in;
      hist_ff    <= hist_in;
      cnt_ff     <= cnt_in;
      idx_ff     <= idx_in;
      hv_ff      <= hv_in;
      hn_ff      <= hn_in;
      ekind_ff   <= ekind_in;
      ok_ff      <= ok_in;
      osrc_ff    <= osrc_in;
      odat_ff    <= odat_in;
      olen_ff    <= olen_in;
      oadr_ff    <= oadr_in;
      olast_ff   <= olast_in;
   end

endmodule
`default_nettype wire

// ===== rtl/at_response_line_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Modem response line parser. Received characters enter one per request on
// the req_ channel at up to one request per clock; they are stored in a line
// buffer until CR LF closes the line. Each non-empty line is classified as an
// OK response, an ERROR response, a "+NNMI:" data notification or a
// "+ROUTE:" event, and other lines are ignored. A data notification yields one
// rsp_ request per decoded payload byte (the last one carries tlast); the
// others yield a single request with tlast set. The result kind travels on
// rsp_tuser. A finished line is handed over through a two-entry line queue to
// the parser, which walks the stored text at most one character per cycle
// through the read port of the line buffer, pausing while the receiver holds
// the result register. For a data line the characters after the source field
// are read a second time when the new form does not fit and the old form is
// tried. A route line is searched for its address only within a window of
// ROUTE_WINDOW characters after the spaces that follow the tag. Input stalls
// only when two finished lines wait in the queue behind the one being parsed.
// The line buffer holds four lines of up to LINE_SIZE - 1 characters each.
module at_response_line_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] source_id, [23:16] data_byte, [30:24] payload_length,
   // [46:31] route_address, [47] zero
   output logic [47:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast
);
   import arlp_pkg::*;

   logic                wr_en;
   logic [RAM_AW-1:0]   wr_addr;
   logic [7:0]          wr_data;
   logic [RAM_AW-1:0]   rd_addr;
   logic [7:0]          rd_data;
   logic                q_full;
   logic                q_push;
   token_type           q_push_token;
   logic                q_pop;
   logic                q_not_empty;
   token_type           q_pop_token;
   logic [1:0]          kind;
   logic [15:0]         source_id;
   logic [7:0]          data_byte;
   logic [6:0]          payload_length;
   logic [15:0]         route_address;

   // Four line banks; the front end fills one while the parser reads another.
   arlp_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Line assembly and on-the-fly classification.
   arlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .byte_data  (req_tdata),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .q_full     (q_full),
      .push       (q_push),
      .push_token (q_push_token)
   );

   arlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_push_token),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_token  (q_pop_token)
   );

   // Field parsing and result generation.
   arlp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_token            (q_pop_token),
      .pop                (q_pop),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .out_kind           (kind),
      .out_source_id      (source_id),
      .out_data_byte      (data_byte),
      .out_payload_length (payload_length),
      .out_route_address  (route_address),
      .out_last           (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, route_address, payload_length, data_byte, source_id};
   assign rsp_tuser = kind;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import arlp_pkg::*;

   // One expected response request, field by field.
   typedef struct {
      logic [1:0]  kind;
      logic [15:0] source_id;
      logic [7:0]  data_byte;
      logic [6:0]  payload_length;
      logic [15:0] route_address;
      logic        last;
   } rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [15:0] source_id, [23:16] data_byte, [30:24] payload_length,
   // [46:31] route_address, [47] zero
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;    // [1:0] kind
   logic        rsp_tlast;

   at_response_line_parser dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   localparam int IDLE_LIMIT = 20000;

   // Predictor state: our own copy of the line buffer.
   logic [7:0] line_buf [0:LINE_SIZE-1];
   int         line_fill;
   int         text_end;

   rsp_type    pending_rsp [$];
   byte        char_queue [$];   // characters still to be offered
   int         mismatches;
   int         lines_ok, lines_err, data_bytes, route_events;
   int         idle_cycles;
   bit         stim_done;
   bit         hold_off;         // long receiver stall requested by stimulus

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int hexv(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic logic [7:0] text_at(input int p);
      return (p < text_end) ? line_buf[p] : 8'h00;
   endfunction

   function automatic bit text_match(input int p, input string s);
      if (p + s.len() > text_end) return 0;
      for (int k = 0; k < s.len(); k++)
         if (line_buf[p+k] != s[k]) return 0;
      return 1;
   endfunction

   // First position at or after from where s occurs wholly below lim, else lim.
   function automatic int text_find(input int from, input int lim, input string s);
      for (int i = from; i + s.len() <= lim; i++) begin
         bit hit;
         hit = 1;
         for (int k = 0; k < s.len(); k++)
            if (line_buf[i+k] != s[k]) hit = 0;
         if (hit) return i;
      end
      return lim;
   endfunction

   function automatic int skip_blanks(input int p);
      while (text_at(p) == CH_SPACE) p++;
      return p;
   endfunction

   function automatic bit scan_hex(inout int p, output int val);
      int q;
      q = p; val = 0;
      while (hexv(text_at(q)) >= 0) begin
         val = ((val << 4) | hexv(text_at(q))) & 16'hFFFF;
         q++;
      end
      if (q == p) return 0;
      p = q;
      return 1;
   endfunction

   function automatic bit scan_dec(inout int p, output int val);
      int q;
      q = p; val = 0;
      while (text_at(q) >= "0" && text_at(q) <= "9") begin
         val = val * 10 + (text_at(q) - "0");
         if (val > 255) val = 255;
         q++;
      end
      if (q == p) return 0;
      p = q;
      return 1;
   endfunction

   function automatic void push_rsp(input logic [1:0] k, input int src, input int d,
                                    input int plen, input int addr, input bit lst);
      rsp_type r;
      r.kind = k; r.source_id = src[15:0]; r.data_byte = d[7:0];
      r.payload_length = plen[6:0]; r.route_address = addr[15:0]; r.last = lst;
      pending_rsp.push_back(r);
   endfunction

   // Decodes a "+NNMI:" notification into payload byte responses.
   function automatic void decode_notification();
      int p, restart, src, v, len;
      bit got;
      p = skip_blanks(6); len = 0; got = 0;
      if (!scan_hex(p, src) || text_at(p) != CH_COMMA) return;
      restart = skip_blanks(p + 1);
      p = restart;
      if (scan_hex(p, v) && text_at(p) == CH_COMMA) begin
         p = skip_blanks(p + 1);
         if (text_at(p) == CH_PLUS || text_at(p) == CH_MINUS) p++;
         if (scan_dec(p, v) && text_at(p) == CH_COMMA) begin
            p = skip_blanks(p + 1);
            if (!scan_dec(p, len) || text_at(p) != CH_COMMA) return;
            got = 1;
         end
      end
      if (!got) begin
         // Old form: the length follows the source directly.
         p = restart;
         if (!scan_dec(p, len) || text_at(p) != CH_COMMA) return;
      end
      p = skip_blanks(p + 1);
      if (len > MAX_PAYLOAD) return;
      if (text_end < p || (text_end - p) / 2 < len) return;
      for (int i = 0; i < len; i++) begin
         int h, l, b;
         h = hexv(text_at(p + 2*i));
         l = hexv(text_at(p + 2*i + 1));
         b = (h < 0) ? 0 : (l < 0) ? h : h * 16 + l;
         push_rsp(KIND_DATA, src, b, len, 0, i + 1 == len);
      end
   endfunction

   function automatic void decode_route();
      int p, lim, a, cnt, addr;
      p = skip_blanks(7); cnt = 0; addr = 0;
      lim = (text_end > p + ROUTE_WINDOW) ? p + ROUTE_WINDOW : text_end;
      if (lim < p) lim = p;
      a = text_find(p, lim, "ADDR[");
      if (a < lim) begin
         for (int q = a + 5; q < lim && line_buf[q] != CH_RBRK && cnt < 8; q++) begin
            if (hexv(line_buf[q]) >= 0) begin
               addr = ((addr << 4) | hexv(line_buf[q])) & 16'hFFFF;
               cnt++;
            end
         end
      end
      push_rsp(KIND_ROUTE, 0, 0, 0, addr, 1);
   endfunction

   function automatic void classify_line();
      int i;
      if (text_end == 0) return;
      if (text_end == 2 && text_match(0, "OK")) begin
         push_rsp(KIND_OK, 0, 0, 0, 0, 1);
         return;
      end
      if (line_buf[0] == CH_PLUS) begin
         i = text_find(0, text_end, ":OK");
         if (i < text_end && i + 3 == text_end) begin
            push_rsp(KIND_OK, 0, 0, 0, 0, 1);
            return;
         end
      end
      if (text_match(0, "ERROR") ||
          (line_buf[0] == CH_PLUS && text_find(0, text_end, ":ERROR") < text_end)) begin
         push_rsp(KIND_ERROR, 0, 0, 0, 0, 1);
         return;
      end
      if (text_match(0, "+NNMI:")) decode_notification();
      else if (text_match(0, "+ROUTE:")) decode_route();
   endfunction

   // Advances the predictor by one accepted character.
   function automatic void predict_char(input logic [7:0] c);
      if (line_fill < LINE_SIZE - 1) begin
         line_buf[line_fill] = c;
         line_fill++;
      end else begin
         // A full buffer drops the character and the whole line with it.
         line_fill = 0;
         return;
      end
      if (line_fill >= 2 && line_buf[line_fill-2] == CH_CR && line_buf[line_fill-1] == CH_LF)
      begin
         text_end = line_fill - 2;
         for (int i = 0; i < line_fill - 2; i++)
            if (line_buf[i] == 8'h00) begin
               text_end = i;
               break;
            end
         classify_line();
         line_fill = 0;
      end
   endfunction

   function automatic void queue_text(input string s);
      for (int k = 0; k < s.len(); k++) char_queue.push_back(s[k]);
   endfunction

   function automatic void queue_line(input string s);
      queue_text(s);
      char_queue.push_back(CH_CR);
      char_queue.push_back(CH_LF);
   endfunction

   function automatic string hex_pairs(input int n);
      string s, t;
      s = "";
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 1) != 0) t = $sformatf("%02x", $urandom_range(0, 255));
         else t = $sformatf("%02X", $urandom_range(0, 255));
         s = {s, t};
      end
      return s;
   endfunction

   // Builds one random line: notifications most often, other responses, plus noise.
   function automatic void queue_random_line();
      int    sel, len;
      string s;
      sel = $urandom_range(0, 19);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PAYLOAD + 2)
                                        : $urandom_range(0, 6);
      case (sel)
         0, 1, 2, 3, 4, 5: begin
            s = $sformatf("+NNMI:%s%0x,%0x,%s%0d,%0d,%s%s",
                          ($urandom % 2) ? " " : "", $urandom_range(0, 65535),
                          $urandom_range(0, 65535), ($urandom % 2) ? "-" : "",
                          $urandom_range(0, 120), len, ($urandom % 3) ? "" : " ",
                          hex_pairs(len));
            // Occasionally the payload is cut short or corrupted.
            if ($urandom_range(0, 7) == 0 && s.len() > 8)
               s = s.substr(0, s.len() - 2);
            if ($urandom_range(0, 7) == 0 && s.len() > 8)
               s[$urandom_range(6, s.len() - 1)] = $urandom_range(32, 126);
            queue_line(s);
         end
         6, 7, 8: queue_line($sformatf("+NNMI:%0X,%0d,%s", $urandom_range(0, 65535),
                                       len, hex_pairs(len)));
         9: queue_line("OK");
         10: queue_line("ERROR");
         11: queue_line($sformatf("+X%0d:OK", $urandom_range(0, 99)));
         12: queue_line($sformatf("+CM:%0d:ERROR", $urandom_range(0, 99)));
         13, 14: queue_line($sformatf("+ROUTE: %0d ADDR[%0x]", $urandom_range(0, 9),
                                      $urandom_range(0, 32'hFFFFF)));
         15: queue_line("");
         default: begin
            int n;
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++) char_queue.push_back(byte'($urandom_range(0, 255)));
            char_queue.push_back(CH_CR);
            char_queue.push_back(CH_LF);
         end
      endcase
   endfunction

   // Directed table: each row is one line; a typed expectation checks the
   // predictor itself where the answer is obvious.
   typedef struct {
      string      text;
      bit         has_expect;
      logic [1:0] kind;
      int         addr;
   } line_row_type;

   line_row_type directed_lines [] = '{
      '{"OK", 1, KIND_OK, 0},
      '{"ERROR", 1, KIND_ERROR, 0},
      '{"ERROR: 5", 1, KIND_ERROR, 0},
      '{"+CSQ:OK", 1, KIND_OK, 0},
      '{"+CMD:ERROR", 1, KIND_ERROR, 0},
      '{"", 0, KIND_OK, 0},
      '{"OKAY", 0, KIND_OK, 0},
      '{"+ROUTE: ADDR[FFFF]", 1, KIND_ROUTE, 16'hFFFF},
      '{"+ROUTE:ADDR[12345678]", 1, KIND_ROUTE, 16'h5678},
      '{"+ROUTE: none", 1, KIND_ROUTE, 0},
      '{"+ROUTE: ADDR[a-b c]", 1, KIND_ROUTE, 16'h0abc},
      '{"+NNMI:FFFF,0001,-70,3,00ff7A", 0, KIND_OK, 0},
      '{"+NNMI: 0,2,+5,1,AB", 0, KIND_OK, 0},
      '{"+NNMI:1234,2,abcd", 0, KIND_OK, 0},
      '{"+NNMI:12,xy,3,zz1g", 0, KIND_OK, 0},
      '{"+NNMI:12,3,4,0,", 0, KIND_OK, 0},
      '{"+NNMI:12,3,4,65,00", 0, KIND_OK, 0},
      '{"+NNMI:12,3,4,3,0011", 0, KIND_OK, 0},
      '{"+NNMI:0x12,1,00", 0, KIND_OK, 0},
      '{"+NNMI:12,1,1,999,00", 0, KIND_OK, 0}
   };

   // Sender: one character per request with a random gap before each.
   int chars_sent;
   int burst_end;
   initial begin
      int gap;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      line_fill = 0;
      text_end = 0;
      chars_sent = 0;
      burst_end = 0;
      stim_done = 0;
      hold_off = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_lines[r]) begin
         queue_line(directed_lines[r].text);
         // A NUL ends the text early.
         if (r == 0) begin
            queue_text("OK");
            char_queue.push_back(8'h00);
            queue_line("junk");
         end
      end
      // A 64-byte payload hits the largest size.
      queue_line({"+NNMI:AB,64,", hex_pairs(64)});
      // An over-long line is dropped; the characters after the drop start a new line.
      for (int k = 0; k < LINE_SIZE + 3; k++) char_queue.push_back("A");
      queue_line("OK");

      while (chars_sent < 1000 || char_queue.size() != 0) begin
         if (char_queue.size() == 0) begin
            queue_random_line();
            // Once in the run, stall the receiver while a burst of data lines flows.
            if (!hold_off) begin
               hold_off = 1;
               repeat (6) queue_line({"+NNMI:1,8,", hex_pairs(8)});
               burst_end = chars_sent + char_queue.size();
            end
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (chars_sent < burst_end) gap = 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= char_queue.pop_front();
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         predict_char(req_tdata);
         chars_sent++;
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
      stim_done = 1;
   end

   // Checks the directed rows whose answer is typed in the table.
   initial begin
      @(negedge reset);
      #1;
      foreach (directed_lines[r]) begin
         if (directed_lines[r].has_expect) begin
            line_buf = '{default: 8'h00};
            text_end = directed_lines[r].text.len();
            for (int k = 0; k < text_end; k++) line_buf[k] = directed_lines[r].text[k];
            begin
               rsp_type saved [$];
               saved = pending_rsp;
               pending_rsp.delete();
               classify_line();
               if (pending_rsp.size() != 1) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("table row %0d: expected one response, predictor gave %0d",
                              r, pending_rsp.size());
               end else if (pending_rsp[0].kind != directed_lines[r].kind ||
                            pending_rsp[0].route_address != directed_lines[r].addr[15:0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("table row %0d: expected kind=%0d addr=%h, got kind=%0d addr=%h",
                              r, directed_lines[r].kind, directed_lines[r].addr[15:0],
                              pending_rsp[0].kind, pending_rsp[0].route_address);
               end
               pending_rsp = saved;
            end
         end
      end
      line_buf = '{default: 8'h00};
      text_end = 0;
   end

   // Receiver: random ready pattern, one long stall when requested.
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off && stall >= 0) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            stall = -1;
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         if ($urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   // Response checker at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: kind=%0d data=%h last=%b",
                        rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser != want.kind || rsp_tdata[15:0] != want.source_id ||
                rsp_tdata[23:16] != want.data_byte ||
                rsp_tdata[30:24] != want.payload_length ||
                rsp_tdata[46:31] != want.route_address || rsp_tdata[47] != 1'b0 ||
                rsp_tlast != want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected kind=%0d src=%h byte=%h len=%0d addr=%h last=%b, got kind=%0d data=%h last=%b",
                           want.kind, want.source_id, want.data_byte, want.payload_length,
                           want.route_address, want.last, rsp_tuser, rsp_tdata, rsp_tlast);
            end
            case (want.kind)
               KIND_OK: lines_ok++;
               KIND_ERROR: lines_err++;
               KIND_DATA: data_bytes++;
               default: route_events++;
            endcase
         end
      end
   end

   // Watchdog on cycles with no accepted request on either side, and the end.
   initial begin
      idle_cycles = 0;
      mismatches = 0;
      lines_ok = 0; lines_err = 0; data_bytes = 0; route_events = 0;
      @(negedge reset);
      while (!(stim_done && pending_rsp.size() == 0) && idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", pending_rsp.size());
         $display("tb: failure");
      end else begin
         // Allow the parser to finish any line that yields nothing.
         repeat (600) @(posedge clock);
         $display("covered %0d characters: %0d ok, %0d error, %0d payload bytes, %0d route",
                  chars_sent, lines_ok, lines_err, data_bytes, route_events);
         $display("directed lines, an over-long line, a long receiver stall and random lines");
         if (mismatches == 0 && pending_rsp.size() == 0) $display("tb: success");
         else $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/arlp_pkg.sv
rtl/arlp_ram.sv
rtl/arlp_front.sv
rtl/arlp_queue.sv
rtl/arlp_back.sv
rtl/at_response_line_parser.sv
tb/sv/tb_top.sv
